// ===== src/pfu_pkg.sv =====
// ============================================================================
// pfu_pkg
// Shared types, constants and helper functions of the particle fountain
// update unit.
// ============================================================================
`default_nettype none

package pfu_pkg;

   localparam int unsigned NumParticlesDefault = 1024;
   localparam int unsigned IndexWidth          = 10;
   localparam int unsigned FracWidth           = 12;
   localparam int unsigned EnergyWidth         = 13;
   localparam int unsigned QuoWidth            = 15;
   localparam int unsigned CsrIndexWidth       = 3;
   localparam int unsigned CsrDataWidth        = 15;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_EJECT_RADIUS = 3'd0,
      CSR_TIME_STEP    = 3'd1,
      CSR_VERT_SPEED   = 3'd2,
      CSR_LAT_SPEED    = 3'd3,
      CSR_JITTER       = 3'd4
   } csr_index_type;

   localparam logic ACTION_SPAWN = 1'b0;
   localparam logic ACTION_STEP  = 1'b1;

   localparam logic [11:0]          EJECT_RADIUS_RESET = 12'd410;
   localparam logic [11:0]          TIME_STEP_RESET    = 12'd61;
   localparam logic [14:0]          VERT_SPEED_RESET   = 15'd16384;
   localparam logic [14:0]          LAT_SPEED_RESET    = 15'd4096;
   localparam logic [11:0]          JITTER_RESET       = 12'd410;

   localparam logic [12:0]          SPAWN_HEIGHT       = 13'd614;
   localparam logic signed [15:0]   RESPAWN_BELOW      = 16'sd410;
   localparam logic [EnergyWidth-1:0] ENERGY_ONE       = 13'd4096;
   localparam logic [EnergyWidth-1:0] ENERGY_DROP      = 13'd41;
   localparam logic [11:0]          FADE_MUL           = 12'd3891;
   localparam logic [15:0]          GRAVITY            = 16'd40141;
   localparam logic [QuoWidth-1:0]  SIZE_MAX           = 15'd32767;

   // half size numerator 0.1 * 2^24; the top bits seed the divider remainder
   localparam int unsigned SizeNum    = 410 * 4096;
   localparam int unsigned DivRemInit = SizeNum >> QuoWidth;
   localparam int unsigned DivNumLow  = SizeNum % (1 << QuoWidth);

   localparam logic [12:0] QUARTER_SINE [33] = '{
      13'd0,    13'd201,  13'd401,  13'd601,  13'd799,  13'd995,  13'd1189,
      13'd1380, 13'd1567, 13'd1751, 13'd1931, 13'd2106, 13'd2276, 13'd2440,
      13'd2598, 13'd2751, 13'd2896, 13'd3035, 13'd3166, 13'd3290, 13'd3406,
      13'd3513, 13'd3612, 13'd3703, 13'd3784, 13'd3857, 13'd3920, 13'd3973,
      13'd4017, 13'd4052, 13'd4076, 13'd4091, 13'd4096
   };

   typedef struct packed {
      logic signed [15:0]     pos_x;
      logic signed [15:0]     pos_y;
      logic signed [15:0]     pos_z;
      logic signed [15:0]     vel_x;
      logic signed [15:0]     vel_y;
      logic signed [15:0]     vel_z;
      logic [11:0]            red;
      logic [11:0]            green;
      logic [11:0]            blue;
      logic [EnergyWidth-1:0] energy;
   } particle_type;

   typedef struct packed {
      logic                  action;
      logic [IndexWidth-1:0] particle_index;
      logic [FracWidth-1:0]  rand_angle;
      logic [FracWidth-1:0]  rand_radius_x;
      logic [FracWidth-1:0]  rand_radius_z;
      logic [FracWidth-1:0]  rand_jitter_x;
      logic [FracWidth-1:0]  rand_jitter_y;
      logic [FracWidth-1:0]  rand_jitter_z;
      logic [FracWidth-1:0]  rand_red;
      logic [FracWidth-1:0]  rand_green;
      logic [FracWidth-1:0]  rand_blue;
      logic [FracWidth-1:0]  rand_vert;
   } req_type;

   function automatic logic [12:0] quarter_lookup(input logic [10:0] p);
      logic [5:0]  idx_lo;
      logic [5:0]  idx_hi;
      logic [7:0]  diff;
      logic [12:0] prod;
      idx_lo = {1'b0, p[9:5]};
      idx_hi = idx_lo + 6'd1;
      diff   = 8'(QUARTER_SINE[idx_hi] - QUARTER_SINE[idx_lo]);
      prod   = 13'(diff * p[4:0]);
      if (p[10]) begin
         return QUARTER_SINE[32];
      end
      return QUARTER_SINE[idx_lo] + {5'd0, prod[12:5]};
   endfunction

   function automatic logic signed [13:0] sine12(input logic [11:0] a);
      logic [10:0] p;
      logic [12:0] m;
      p = a[10] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
      m = quarter_lookup(p);
      return a[11] ? -$signed({1'b0, m}) : $signed({1'b0, m});
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] x);
      if (x > 48'sd32767) begin
         return 16'sh7fff;
      end
      if (x < -48'sd32768) begin
         return 16'sh8000;
      end
      return x[15:0];
   endfunction

   // one restoring step: returns next remainder and quotient bit
   function automatic logic [EnergyWidth:0] div_step(input logic [EnergyWidth-1:0] rem,
                                                     input logic [EnergyWidth-1:0] d,
                                                     input logic nbit);
      logic [EnergyWidth:0] trial;
      trial = {rem, nbit};
      if (trial >= {1'b0, d}) begin
         return {EnergyWidth'(trial - {1'b0, d}), 1'b1};
      end
      return {trial[EnergyWidth-1:0], 1'b0};
   endfunction

endpackage

`default_nettype wire

// ===== src/pfu_req_if.sv =====
// ============================================================================
// pfu_req_if
// Request channel: spawn or step transaction for one particle.
// ============================================================================
`default_nettype none

interface pfu_req_if import pfu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  action;
   logic [IndexWidth-1:0] particle_index;
   logic [FracWidth-1:0]  rand_angle;
   logic [FracWidth-1:0]  rand_radius_x;
   logic [FracWidth-1:0]  rand_radius_z;
   logic [FracWidth-1:0]  rand_jitter_x;
   logic [FracWidth-1:0]  rand_jitter_y;
   logic [FracWidth-1:0]  rand_jitter_z;
   logic [FracWidth-1:0]  rand_red;
   logic [FracWidth-1:0]  rand_green;
   logic [FracWidth-1:0]  rand_blue;
   logic [FracWidth-1:0]  rand_vert;

   modport source (
      output valid, action, particle_index, rand_angle, rand_radius_x, rand_radius_z,
             rand_jitter_x, rand_jitter_y, rand_jitter_z, rand_red, rand_green,
             rand_blue, rand_vert,
      input  ready
   );
   modport sink (
      input  valid, action, particle_index, rand_angle, rand_radius_x, rand_radius_z,
             rand_jitter_x, rand_jitter_y, rand_jitter_z, rand_red, rand_green,
             rand_blue, rand_vert,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/pfu_rsp_if.sv =====
// ============================================================================
// pfu_rsp_if
// Response channel: particle state as reported by a step transaction.
// ============================================================================
`default_nettype none

interface pfu_rsp_if import pfu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [IndexWidth-1:0] out_index;
   logic signed [15:0]    pos_x;
   logic signed [15:0]    pos_y;
   logic signed [15:0]    pos_z;
   logic [QuoWidth-1:0]   half_size;
   logic [FracWidth-1:0]  red;
   logic [FracWidth-1:0]  green;
   logic [FracWidth-1:0]  blue;

   modport source (
      output valid, out_index, pos_x, pos_y, pos_z, half_size, red, green, blue,
      input  ready
   );
   modport sink (
      input  valid, out_index, pos_x, pos_y, pos_z, half_size, red, green, blue,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/particle_fountain_update_unit.sv =====
// ============================================================================
// particle_fountain_update_unit
// Particle table with spawn and Euler step update, five stage pipeline
// around a read-modify-write particle RAM.
// ============================================================================
//
//   channel      direction  transaction
//   req_channel  in         spawn or step of one particle
//   rsp_channel  out        position, half size and colour of a stepped particle
//   csr_*        in         register write, no read-back
//
// One transaction per cycle unless a hazard or a response stall holds it back.
// A request whose particle is still in flight in the pipeline waits until
// that particle has been written back (read-modify-write on the RAM port).
// Reset clears valid bits and presets the CSRs; the particle RAM is not cleared.
// A stalled response holds the last stage only for step transactions.
// ============================================================================
`default_nettype none

module particle_fountain_update_unit
   import pfu_pkg::*;
#(
   parameter int unsigned NUM_PARTICLES = NumParticlesDefault
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   pfu_req_if.sink                       req_channel,
   pfu_rsp_if.source                     rsp_channel,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data
);

   localparam int unsigned AddrWidth = (NUM_PARTICLES > 1) ? $clog2(NUM_PARTICLES) : 1;

   typedef struct packed {
      logic                  step;
      logic [IndexWidth-1:0] idx;
      logic [11:0]           rx;
      logic [11:0]           rz;
      logic [11:0]           rr;
      logic [11:0]           rg;
      logic [11:0]           rb;
      particle_type          old;
      logic [11:0]           fr;
      logic [11:0]           fg;
      logic [11:0]           fb;
      logic [EnergyWidth-1:0] e_dec;
      logic signed [13:0]    s;
      logic signed [13:0]    c;
      logic [23:0]           jxm;
      logic [23:0]           jym;
      logic [23:0]           jzm;
      logic [26:0]           rvm;
      logic [15:0]           dv;
   } s2_type;

   typedef struct packed {
      logic                  step;
      logic [IndexWidth-1:0] idx;
      logic [11:0]           rx;
      logic [11:0]           rz;
      logic [11:0]           rr;
      logic [11:0]           rg;
      logic [11:0]           rb;
      particle_type          old;
      logic signed [15:0]    vy_new;
      logic [11:0]           fr;
      logic [11:0]           fg;
      logic [11:0]           fb;
      logic [EnergyWidth-1:0] e_dec;
      logic signed [26:0]    sr;
      logic signed [26:0]    cr;
      logic signed [30:0]    sl;
      logic signed [30:0]    cl;
      logic [11:0]           jx;
      logic [11:0]           jy;
      logic [11:0]           jz;
      logic signed [15:0]    vy_spawn;
   } s3_type;

   typedef struct packed {
      logic                  step;
      logic [IndexWidth-1:0] idx;
      logic [11:0]           rr;
      logic [11:0]           rg;
      logic [11:0]           rb;
      particle_type          old;
      logic signed [15:0]    vy_new;
      logic [11:0]           fr;
      logic [11:0]           fg;
      logic [11:0]           fb;
      logic [EnergyWidth-1:0] e_dec;
      logic [11:0]           jx;
      logic [11:0]           jy;
      logic [11:0]           jz;
      logic signed [15:0]    vy_spawn;
      logic signed [39:0]    srx;
      logic signed [39:0]    crz;
      logic signed [43:0]    slx;
      logic signed [43:0]    clz;
      logic signed [28:0]    dtvx;
      logic signed [28:0]    dtvy;
      logic signed [28:0]    dtvz;
   } s4_type;

   typedef struct packed {
      logic                  step;
      logic [IndexWidth-1:0] idx;
      logic signed [15:0]    pos_x;
      logic signed [15:0]    pos_y;
      logic signed [15:0]    pos_z;
      logic [11:0]           red;
      logic [11:0]           green;
      logic [11:0]           blue;
      particle_type          upd;
   } s5_type;

   // configuration
   logic [11:0] eject_radius_ff;
   logic [11:0] time_step_ff;
   logic [14:0] vert_speed_ff;
   logic [14:0] lat_speed_ff;
   logic [11:0] jitter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         eject_radius_ff <= EJECT_RADIUS_RESET;
         time_step_ff    <= TIME_STEP_RESET;
         vert_speed_ff   <= VERT_SPEED_RESET;
         lat_speed_ff    <= LAT_SPEED_RESET;
         jitter_ff       <= JITTER_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_EJECT_RADIUS: begin
               eject_radius_ff <= csr_write_data[11:0];
            end
            CSR_TIME_STEP: begin
               time_step_ff <= csr_write_data[11:0];
            end
            CSR_VERT_SPEED: begin
               vert_speed_ff <= csr_write_data[14:0];
            end
            CSR_LAT_SPEED: begin
               lat_speed_ff <= csr_write_data[14:0];
            end
            CSR_JITTER: begin
               jitter_ff <= csr_write_data[11:0];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline control
   req_type      req_item;
   req_type      s1_ff;
   s2_type       s2_ff, s2_in;
   s3_type       s3_ff, s3_in;
   s4_type       s4_ff, s4_in;
   s5_type       s5_ff, s5_in;
   logic         v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic         ld1, ld2, ld3, ld4, ld5, adv5, out_ld;
   logic         hazard, accept, in_range;
   particle_type rd_particle;
   logic [QuoWidth-1:0] half_size;

   logic                  rsp_valid_ff;
   logic [IndexWidth-1:0] out_index_ff;
   logic signed [15:0]    pos_x_ff, pos_y_ff, pos_z_ff;
   logic [QuoWidth-1:0]   half_size_ff;
   logic [11:0]           red_ff, green_ff, blue_ff;

   assign req_item.action         = req_channel.action;
   assign req_item.particle_index = req_channel.particle_index;
   assign req_item.rand_angle     = req_channel.rand_angle;
   assign req_item.rand_radius_x  = req_channel.rand_radius_x;
   assign req_item.rand_radius_z  = req_channel.rand_radius_z;
   assign req_item.rand_jitter_x  = req_channel.rand_jitter_x;
   assign req_item.rand_jitter_y  = req_channel.rand_jitter_y;
   assign req_item.rand_jitter_z  = req_channel.rand_jitter_z;
   assign req_item.rand_red       = req_channel.rand_red;
   assign req_item.rand_green     = req_channel.rand_green;
   assign req_item.rand_blue      = req_channel.rand_blue;
   assign req_item.rand_vert      = req_channel.rand_vert;

   assign out_ld = !rsp_valid_ff || rsp_channel.ready;
   assign adv5   = v5_ff && (!s5_ff.step || out_ld);
   assign ld5    = !v5_ff || adv5;
   assign ld4    = !v4_ff || ld5;
   assign ld3    = !v3_ff || ld4;
   assign ld2    = !v2_ff || ld3;
   assign ld1    = !v1_ff || ld2;

   assign hazard = (v1_ff && s1_ff.particle_index == req_item.particle_index) ||
                   (v2_ff && s2_ff.idx == req_item.particle_index) ||
                   (v3_ff && s3_ff.idx == req_item.particle_index) ||
                   (v4_ff && s4_ff.idx == req_item.particle_index) ||
                   (v5_ff && s5_ff.idx == req_item.particle_index);

   assign req_channel.ready = ld1 && !hazard;
   assign accept            = req_channel.valid && req_channel.ready;
   assign in_range          = 32'(req_item.particle_index) < NUM_PARTICLES;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (ld1) begin
            v1_ff <= accept && in_range;
         end
         if (ld2) begin
            v2_ff <= v1_ff;
         end
         if (ld3) begin
            v3_ff <= v2_ff;
         end
         if (ld4) begin
            v4_ff <= v3_ff;
         end
         if (ld5) begin
            v5_ff <= v4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld1 && accept) begin
         s1_ff <= req_item;
      end
      if (ld2) begin
         s2_ff <= s2_in;
      end
      if (ld3) begin
         s3_ff <= s3_in;
      end
      if (ld4) begin
         s4_ff <= s4_in;
      end
      if (ld5) begin
         s5_ff <= s5_in;
      end
   end

   pfu_ram #(
      .WIDTH ($bits(particle_type)),
      .DEPTH (NUM_PARTICLES)
   ) u_particle_ram (
      .clock   (clock),
      .wr_en   (adv5),
      .wr_addr (AddrWidth'(s5_ff.idx)),
      .wr_data (s5_ff.upd),
      .rd_en   (accept),
      .rd_addr (AddrWidth'(req_item.particle_index)),
      .rd_data (rd_particle)
   );

   pfu_div u_div (
      .clock     (clock),
      .load      ({ld5, ld4, ld3, ld2}),
      .energy    (rd_particle.energy),
      .half_size (half_size)
   );

   // stage 1: sine/cosine, jitter, colour, lift and gravity products, energy age
   logic [23:0] fr_prod, fg_prod, fb_prod;
   logic [27:0] dv_prod;

   always_comb begin
      fr_prod = 24'(rd_particle.red) * 24'(FADE_MUL);
      fg_prod = 24'(rd_particle.green) * 24'(FADE_MUL);
      fb_prod = 24'(rd_particle.blue) * 24'(FADE_MUL);
      dv_prod = 28'(GRAVITY) * 28'(time_step_ff);

      s2_in.step  = s1_ff.action == ACTION_STEP;
      s2_in.idx   = s1_ff.particle_index;
      s2_in.rx    = s1_ff.rand_radius_x;
      s2_in.rz    = s1_ff.rand_radius_z;
      s2_in.rr    = s1_ff.rand_red;
      s2_in.rg    = s1_ff.rand_green;
      s2_in.rb    = s1_ff.rand_blue;
      s2_in.old   = rd_particle;
      s2_in.fr    = fr_prod[23:12];
      s2_in.fg    = fg_prod[23:12];
      s2_in.fb    = fb_prod[23:12];
      s2_in.e_dec = (rd_particle.energy > ENERGY_DROP) ?
                    rd_particle.energy - ENERGY_DROP : '0;
      s2_in.s     = sine12(s1_ff.rand_angle);
      s2_in.c     = sine12(s1_ff.rand_angle + 12'd1024);
      s2_in.jxm   = 24'(s1_ff.rand_jitter_x) * 24'(jitter_ff);
      s2_in.jym   = 24'(s1_ff.rand_jitter_y) * 24'(jitter_ff);
      s2_in.jzm   = 24'(s1_ff.rand_jitter_z) * 24'(jitter_ff);
      s2_in.rvm   = 27'(s1_ff.rand_vert) * 27'(vert_speed_ff);
      s2_in.dv    = dv_prod[27:12];
   end

   // stage 2: radius and lateral speed products, gravity on vy
   logic [15:0] vy_sp_sum;

   always_comb begin
      vy_sp_sum = 16'(s2_ff.rvm[26:12]) + 16'(vert_speed_ff[14:1]);

      s3_in.step     = s2_ff.step;
      s3_in.idx      = s2_ff.idx;
      s3_in.rx       = s2_ff.rx;
      s3_in.rz       = s2_ff.rz;
      s3_in.rr       = s2_ff.rr;
      s3_in.rg       = s2_ff.rg;
      s3_in.rb       = s2_ff.rb;
      s3_in.old      = s2_ff.old;
      s3_in.vy_new   = sat16(48'($signed(s2_ff.old.vel_y)) - 48'($signed({1'b0, s2_ff.dv})));
      s3_in.fr       = s2_ff.fr;
      s3_in.fg       = s2_ff.fg;
      s3_in.fb       = s2_ff.fb;
      s3_in.e_dec    = s2_ff.e_dec;
      s3_in.sr       = s2_ff.s * $signed({1'b0, eject_radius_ff});
      s3_in.cr       = s2_ff.c * $signed({1'b0, eject_radius_ff});
      s3_in.sl       = s2_ff.s * $signed({1'b0, lat_speed_ff, 1'b0});
      s3_in.cl       = s2_ff.c * $signed({1'b0, lat_speed_ff, 1'b0});
      s3_in.jx       = s2_ff.jxm[23:12];
      s3_in.jy       = s2_ff.jym[23:12];
      s3_in.jz       = s2_ff.jzm[23:12];
      s3_in.vy_spawn = (vy_sp_sum > 16'd32767) ? 16'sh7fff : $signed(vy_sp_sum);
   end

   // stage 3: random radius products and time step products
   always_comb begin
      s4_in.step     = s3_ff.step;
      s4_in.idx      = s3_ff.idx;
      s4_in.rr       = s3_ff.rr;
      s4_in.rg       = s3_ff.rg;
      s4_in.rb       = s3_ff.rb;
      s4_in.old      = s3_ff.old;
      s4_in.vy_new   = s3_ff.vy_new;
      s4_in.fr       = s3_ff.fr;
      s4_in.fg       = s3_ff.fg;
      s4_in.fb       = s3_ff.fb;
      s4_in.e_dec    = s3_ff.e_dec;
      s4_in.jx       = s3_ff.jx;
      s4_in.jy       = s3_ff.jy;
      s4_in.jz       = s3_ff.jz;
      s4_in.vy_spawn = s3_ff.vy_spawn;
      s4_in.srx      = s3_ff.sr * $signed({1'b0, s3_ff.rx});
      s4_in.crz      = s3_ff.cr * $signed({1'b0, s3_ff.rz});
      s4_in.slx      = s3_ff.sl * $signed({1'b0, s3_ff.rx});
      s4_in.clz      = s3_ff.cl * $signed({1'b0, s3_ff.rz});
      s4_in.dtvx     = $signed({1'b0, time_step_ff}) * $signed(s3_ff.old.vel_x);
      s4_in.dtvy     = $signed({1'b0, time_step_ff}) * s3_ff.vy_new;
      s4_in.dtvz     = $signed({1'b0, time_step_ff}) * $signed(s3_ff.old.vel_z);
   end

   // stage 4: spawn and step results, choose the write-back
   logic signed [17:0] x_sum, z_sum;
   logic [12:0]        y_sum;
   particle_type       spawn_p, step_p;
   logic               respawn;

   always_comb begin
      x_sum = 18'(s4_ff.srx >>> 24) + 18'($signed({1'b0, s4_ff.jx}));
      z_sum = 18'(s4_ff.crz >>> 24) + 18'($signed({1'b0, s4_ff.jz}));
      y_sum = SPAWN_HEIGHT + {1'b0, s4_ff.jy};

      spawn_p.pos_x  = sat16(48'(x_sum));
      spawn_p.pos_y  = $signed({3'd0, y_sum});
      spawn_p.pos_z  = sat16(48'(z_sum));
      spawn_p.vel_x  = sat16(48'(s4_ff.slx >>> 24));
      spawn_p.vel_y  = s4_ff.vy_spawn;
      spawn_p.vel_z  = sat16(48'(s4_ff.clz >>> 24));
      spawn_p.red    = s4_ff.rr;
      spawn_p.green  = s4_ff.rg;
      spawn_p.blue   = s4_ff.rb;
      spawn_p.energy = ENERGY_ONE;

      step_p.pos_x  = sat16(48'($signed(s4_ff.old.pos_x)) + 48'(s4_ff.dtvx >>> 12));
      step_p.pos_y  = sat16(48'($signed(s4_ff.old.pos_y)) + 48'(s4_ff.dtvy >>> 12));
      step_p.pos_z  = sat16(48'($signed(s4_ff.old.pos_z)) + 48'(s4_ff.dtvz >>> 12));
      step_p.vel_x  = s4_ff.old.vel_x;
      step_p.vel_y  = s4_ff.vy_new;
      step_p.vel_z  = s4_ff.old.vel_z;
      step_p.red    = s4_ff.fr;
      step_p.green  = s4_ff.fg;
      step_p.blue   = s4_ff.fb;
      step_p.energy = s4_ff.e_dec;

      respawn = !s4_ff.step || ($signed(s4_ff.old.pos_y) < RESPAWN_BELOW);

      s5_in.step  = s4_ff.step;
      s5_in.idx   = s4_ff.idx;
      s5_in.pos_x = s4_ff.old.pos_x;
      s5_in.pos_y = s4_ff.old.pos_y;
      s5_in.pos_z = s4_ff.old.pos_z;
      s5_in.red   = s4_ff.old.red;
      s5_in.green = s4_ff.old.green;
      s5_in.blue  = s4_ff.old.blue;
      s5_in.upd   = respawn ? spawn_p : step_p;
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ld) begin
         rsp_valid_ff <= adv5 && s5_ff.step;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ld && adv5 && s5_ff.step) begin
         out_index_ff <= s5_ff.idx;
         pos_x_ff     <= s5_ff.pos_x;
         pos_y_ff     <= s5_ff.pos_y;
         pos_z_ff     <= s5_ff.pos_z;
         half_size_ff <= half_size;
         red_ff       <= s5_ff.red;
         green_ff     <= s5_ff.green;
         blue_ff      <= s5_ff.blue;
      end
   end

   assign rsp_channel.valid     = rsp_valid_ff;
   assign rsp_channel.out_index = out_index_ff;
   assign rsp_channel.pos_x     = pos_x_ff;
   assign rsp_channel.pos_y     = pos_y_ff;
   assign rsp_channel.pos_z     = pos_z_ff;
   assign rsp_channel.half_size = half_size_ff;
   assign rsp_channel.red       = red_ff;
   assign rsp_channel.green     = green_ff;
   assign rsp_channel.blue      = blue_ff;

   // checks
   assert property (@(posedge clock) disable iff (reset)
      !(adv5 && accept && s5_ff.idx == req_item.particle_index))
      else $error("particle read while its write-back is pending");

   assert property (@(posedge clock) disable iff (reset)
      adv5 && s5_ff.step |=> rsp_valid_ff)
      else $error("step transaction left the pipeline without a response");

   assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff |-> s1_ff.particle_index != s2_ff.idx)
      else $error("same particle in two adjacent stages");

endmodule

`default_nettype wire

// ===== src/pfu_ram.sv =====
// ============================================================================
// pfu_ram
// Generic single write port, single read port RAM with registered read.
// ============================================================================
`default_nettype none

module pfu_ram #(
   parameter  int unsigned WIDTH = 8,
   parameter  int unsigned DEPTH = 2,
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/pfu_div.sv =====
// ============================================================================
// pfu_div
// Pipelined restoring divider for the sprite half size, 0.1 / energy,
// five quotient bits per stage, saturated at the maximum.
// ============================================================================
`default_nettype none

module pfu_div
   import pfu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic [3:0]             load,      // per stage register load
   input  wire logic [EnergyWidth-1:0] energy,
   output logic      [QuoWidth-1:0]    half_size
);

   localparam int unsigned DivStages        = 3;
   localparam int unsigned DivStepsPerStage = QuoWidth / DivStages;
   localparam logic [QuoWidth-1:0] NUM_LOW  = QuoWidth'(DivNumLow);

   logic [EnergyWidth-1:0] d_ff   [DivStages];
   logic [EnergyWidth-1:0] rem_ff [DivStages];
   logic [QuoWidth-1:0]    q_ff   [DivStages];
   logic                   sat_ff [DivStages];
   logic [EnergyWidth-1:0] rem_in [DivStages];
   logic [QuoWidth-1:0]    q_in   [DivStages];
   logic [EnergyWidth:0]   step_res;
   logic [QuoWidth-1:0]    q_out_ff;
   logic                   sat_out_ff;

   always_comb begin
      step_res = '0;
      for (int k = 0; k < DivStages; k++) begin
         rem_in[k] = rem_ff[k];
         q_in[k]   = q_ff[k];
         for (int j = 0; j < DivStepsPerStage; j++) begin
            step_res  = div_step(rem_in[k], d_ff[k],
                                 NUM_LOW[QuoWidth - 1 - k * DivStepsPerStage - j]);
            rem_in[k] = step_res[EnergyWidth:1];
            q_in[k]   = {q_in[k][QuoWidth-2:0], step_res[0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         d_ff[0]   <= energy;
         sat_ff[0] <= (energy <= EnergyWidth'(DivRemInit));
         rem_ff[0] <= EnergyWidth'(DivRemInit);
         q_ff[0]   <= '0;
      end
      for (int k = 1; k < DivStages; k++) begin
         if (load[k]) begin
            d_ff[k]   <= d_ff[k-1];
            sat_ff[k] <= sat_ff[k-1];
            rem_ff[k] <= rem_in[k-1];
            q_ff[k]   <= q_in[k-1];
         end
      end
      if (load[DivStages]) begin
         sat_out_ff <= sat_ff[DivStages-1];
         q_out_ff   <= q_in[DivStages-1];
      end
   end

   assign half_size = sat_out_ff ? SIZE_MAX : q_out_ff;

endmodule

`default_nettype wire

// ===== sim/tb_particle_fountain_update_unit.sv =====
// ============================================================================
// tb_particle_fountain_update_unit
// Self-checking testbench: drives spawn and step transactions, predicts each
// response from its own fixed point particle table and checks every field.
// ============================================================================
`timescale 1ns / 100ps

module tb_particle_fountain_update_unit
   import pfu_pkg::*;
;

   typedef struct packed {
      logic [IndexWidth-1:0] out_index;
      logic signed [15:0]    pos_x;
      logic signed [15:0]    pos_y;
      logic signed [15:0]    pos_z;
      logic [QuoWidth-1:0]   half_size;
      logic [11:0]           red;
      logic [11:0]           green;
      logic [11:0]           blue;
   } particle_view_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_write_data = '0;

   pfu_req_if req_if ();
   pfu_rsp_if rsp_if ();

   particle_fountain_update_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_if),
      .rsp_channel      (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // predicted particle table and registers
   longint          radius_q, step_q, vspeed_q, lspeed_q, jitter_q;
   longint          pos_tab [NumParticlesDefault][3];
   longint          vel_tab [NumParticlesDefault][3];
   longint          col_tab [NumParticlesDefault][3];
   longint          energy_tab [NumParticlesDefault];
   bit              spawned [NumParticlesDefault];
   int              spawned_list [$];

   particle_view_type views_due [$];
   int  mismatches = 0;
   int  tx_idle = 1;      // 0 no gaps, 1 bursts with gaps
   int  rx_mode = 0;      // 0 always ready, 1 random, 2 pattern
   bit  hold_request = 1'b0;
   int  burst_left = 0;

   initial begin
      req_if.valid = 1'b0;
      {req_if.action, req_if.particle_index, req_if.rand_angle, req_if.rand_radius_x,
       req_if.rand_radius_z, req_if.rand_jitter_x, req_if.rand_jitter_y,
       req_if.rand_jitter_z, req_if.rand_red, req_if.rand_green, req_if.rand_blue,
       req_if.rand_vert} = '0;
      rsp_if.ready = 1'b0;
   end

   function automatic longint sat_q16(longint x);
      if (x > 32767) return 32767;
      if (x < -32768) return -32768;
      return x;
   endfunction

   function automatic longint wave_quarter(int unsigned p);
      int unsigned k;
      longint lo, hi;
      if (p >= 1024) return 4096;
      k  = p >> 5;
      lo = QUARTER_SINE[k];
      hi = QUARTER_SINE[k+1];
      return lo + (((hi - lo) * (p & 31)) >> 5);
   endfunction

   function automatic longint sine_q12(int unsigned a);
      int unsigned r;
      r = a & 1023;
      case ((a >> 10) & 3)
         0: return wave_quarter(r);
         1: return wave_quarter(1024 - r);
         2: return -wave_quarter(r);
         default: return -wave_quarter(1024 - r);
      endcase
   endfunction

   function automatic void launch_particle(req_type t);
      int     i;
      longint s, c;
      longint rx, rz, jx, jy, jz, rv;
      i  = t.particle_index;
      rx = longint'(t.rand_radius_x);
      rz = longint'(t.rand_radius_z);
      jx = longint'(t.rand_jitter_x);
      jy = longint'(t.rand_jitter_y);
      jz = longint'(t.rand_jitter_z);
      rv = longint'(t.rand_vert);
      s = sine_q12(t.rand_angle);
      c = sine_q12((t.rand_angle + 1024) & 4095);
      pos_tab[i][0] = sat_q16(((s * radius_q * rx) >>> 24) + ((jx * jitter_q) >>> 12));
      pos_tab[i][1] = sat_q16(614 + ((jy * jitter_q) >>> 12));
      pos_tab[i][2] = sat_q16(((c * radius_q * rz) >>> 24) + ((jz * jitter_q) >>> 12));
      vel_tab[i][0] = sat_q16((2 * lspeed_q * s * rx) >>> 24);
      vel_tab[i][1] = sat_q16(((rv * vspeed_q) >>> 12) + (vspeed_q >>> 1));
      vel_tab[i][2] = sat_q16((2 * lspeed_q * c * rz) >>> 24);
      col_tab[i][0] = t.rand_red;
      col_tab[i][1] = t.rand_green;
      col_tab[i][2] = t.rand_blue;
      energy_tab[i] = 4096;
      if (!spawned[i]) begin
         spawned[i] = 1'b1;
         spawned_list.push_back(i);
      end
   endfunction

   function automatic void age_particle(req_type t);
      int                i;
      longint            e;
      particle_view_type v;
      i = t.particle_index;
      e = energy_tab[i];
      v.out_index = i;
      v.pos_x     = pos_tab[i][0];
      v.pos_y     = pos_tab[i][1];
      v.pos_z     = pos_tab[i][2];
      v.half_size = (e == 0 || (410 * 4096) / e > 32767) ? 32767 : (410 * 4096) / e;
      v.red       = col_tab[i][0];
      v.green     = col_tab[i][1];
      v.blue      = col_tab[i][2];
      views_due.push_back(v);
      energy_tab[i] = e > 41 ? e - 41 : 0;
      for (int k = 0; k < 3; k++) col_tab[i][k] = (col_tab[i][k] * 3891) >> 12;
      if (pos_tab[i][1] < 410) begin
         launch_particle(t);
      end else begin
         vel_tab[i][1] = sat_q16(vel_tab[i][1] - ((40141 * step_q) >>> 12));
         for (int k = 0; k < 3; k++)
            pos_tab[i][k] = sat_q16(pos_tab[i][k] + ((step_q * vel_tab[i][k]) >>> 12));
      end
   endfunction

   function automatic logic [11:0] pick_frac();
      case ($urandom_range(0, 9))
         0: return 12'd0;
         1: return 12'd4095;
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   function automatic req_type make_item(logic act, int idx);
      req_type t;
      t.action         = act;
      t.particle_index = IndexWidth'(idx);
      t.rand_angle     = pick_frac();
      t.rand_radius_x  = pick_frac();
      t.rand_radius_z  = pick_frac();
      t.rand_jitter_x  = pick_frac();
      t.rand_jitter_y  = pick_frac();
      t.rand_jitter_z  = pick_frac();
      t.rand_red       = pick_frac();
      t.rand_green     = pick_frac();
      t.rand_blue      = pick_frac();
      t.rand_vert      = pick_frac();
      return t;
   endfunction

   task automatic send_item(req_type t);
      int gap;
      if (tx_idle != 0 && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      if (burst_left > 0) burst_left--;
      req_if.valid          <= 1'b1;
      req_if.action         <= t.action;
      req_if.particle_index <= t.particle_index;
      req_if.rand_angle     <= t.rand_angle;
      req_if.rand_radius_x  <= t.rand_radius_x;
      req_if.rand_radius_z  <= t.rand_radius_z;
      req_if.rand_jitter_x  <= t.rand_jitter_x;
      req_if.rand_jitter_y  <= t.rand_jitter_y;
      req_if.rand_jitter_z  <= t.rand_jitter_z;
      req_if.rand_red       <= t.rand_red;
      req_if.rand_green     <= t.rand_green;
      req_if.rand_blue      <= t.rand_blue;
      req_if.rand_vert      <= t.rand_vert;
      do @(posedge clock); while (!req_if.ready);
      if (t.action == ACTION_SPAWN) launch_particle(t);
      else age_particle(t);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (views_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CsrDataWidth'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_EJECT_RADIUS: radius_q = value & 4095;
         CSR_TIME_STEP:    step_q   = value & 4095;
         CSR_VERT_SPEED:   vspeed_q = value & 32767;
         CSR_LAT_SPEED:    lspeed_q = value & 32767;
         CSR_JITTER:       jitter_q = value & 4095;
         default: ;
      endcase
   endtask

   // response side: stall pattern plus one long hold-off on request
   int rx_cycle = 0;
   int hold_left = 0;
   always @(posedge clock) begin
      rx_cycle++;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 400;
         rsp_if.ready <= 1'b0;
      end else begin
         case (rx_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 9) < 7);
            default: rsp_if.ready <= ((rx_cycle % 13) < 8);
         endcase
      end
   end

   always @(posedge clock) begin
      particle_view_type want, got;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = '{rsp_if.out_index, rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z,
                 rsp_if.half_size, rsp_if.red, rsp_if.green, rsp_if.blue};
         if (views_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: %p", got);
         end else begin
            want = views_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic test_default_registers();
      send_item(make_item(ACTION_SPAWN, 0));
      send_item(make_item(ACTION_SPAWN, 1023));
      for (int a = 0; a < 4; a++) begin
         req_type t;
         t = make_item(ACTION_SPAWN, 10 + a);
         t.rand_angle = 12'(a * 1024 + (a == 3 ? 1023 : 0));
         send_item(t);
      end
      for (int k = 0; k < 4; k++) send_item(make_item(ACTION_STEP, 10 + k));
      send_item(make_item(ACTION_STEP, 0));
      send_item(make_item(ACTION_STEP, 1023));
      send_item(make_item(ACTION_STEP, 1023));
   endtask

   task automatic test_energy_exhaustion();
      // particle held in place ages until the half size saturates and energy bottoms out
      write_reg(CSR_TIME_STEP, 0);
      send_item(make_item(ACTION_SPAWN, 7));
      repeat (104) send_item(make_item(ACTION_STEP, 7));
   endtask

   task automatic test_falling_respawn();
      // no lift and a large step: the particle drops below the floor and respawns
      write_reg(CSR_TIME_STEP, 4095);
      write_reg(CSR_VERT_SPEED, 0);
      write_reg(CSR_EJECT_RADIUS, 0);
      send_item(make_item(ACTION_SPAWN, 300));
      repeat (6) send_item(make_item(ACTION_STEP, 300));
   endtask

   task automatic test_register_extremes();
      write_reg(CSR_EJECT_RADIUS, 4095);
      write_reg(CSR_VERT_SPEED, 32767);
      write_reg(CSR_LAT_SPEED, 32767);
      write_reg(CSR_JITTER, 4095);
      for (int k = 0; k < 4; k++) send_item(make_item(ACTION_SPAWN, 500 + k));
      for (int k = 0; k < 12; k++) send_item(make_item(ACTION_STEP, 500 + (k % 4)));
      write_reg(CSR_LAT_SPEED, 0);
      write_reg(CSR_JITTER, 0);
      send_item(make_item(ACTION_SPAWN, 504));
      send_item(make_item(ACTION_STEP, 504));
   endtask

   task automatic random_phase(int count, bit hazards);
      int idx;
      for (int n = 0; n < count; n++) begin
         if (spawned_list.size() == 0 || $urandom_range(0, 99) < 25) begin
            idx = hazards ? $urandom_range(0, 7) : $urandom_range(0, 1023);
            send_item(make_item(ACTION_SPAWN, idx));
         end else begin
            idx = spawned_list[$urandom_range(0, spawned_list.size() - 1)];
            if (hazards && spawned[n % 8]) idx = n % 8;
            send_item(make_item(ACTION_STEP, idx));
         end
      end
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_EJECT_RADIUS, $urandom_range(0, 4095));
         write_reg(CSR_TIME_STEP, p == 0 ? 1 : $urandom_range(1, 4095));
         write_reg(CSR_VERT_SPEED, $urandom_range(0, 32767));
         write_reg(CSR_LAT_SPEED, $urandom_range(0, 32767));
         write_reg(CSR_JITTER, $urandom_range(0, 4095));
         tx_idle = p % 3 == 0 ? 0 : 1;
         rx_mode = p % 3;
         random_phase(150, p[0]);
      end
   endtask

   task automatic test_back_pressure();
      write_reg(CSR_TIME_STEP, 61);
      write_reg(CSR_VERT_SPEED, 16384);
      tx_idle = 0;
      rx_mode = 0;
      hold_request = 1'b1;
      random_phase(200, 1'b0);
   endtask

   initial begin
      radius_q = EJECT_RADIUS_RESET;
      step_q   = TIME_STEP_RESET;
      vspeed_q = VERT_SPEED_RESET;
      lspeed_q = LAT_SPEED_RESET;
      jitter_q = JITTER_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_registers();
      test_energy_exhaustion();
      test_falling_respawn();
      test_register_extremes();
      test_random_settings();
      test_back_pressure();
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && views_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
